// ===== hdl/mcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpt_pkg: shared types and constants for the periodic timer bank
// Kinds, states, status codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package mcpt_pkg;
	localparam int NumSlots  = 16;
	localparam int SlotW     = 4;
	localparam int FireMax   = 100000;
	localparam int DivLimit  = 54925;

	typedef enum logic [2:0] {
		KIND_TICK = 3'd0, KIND_ALLOC = 3'd1, KIND_RELEASE = 3'd2,
		KIND_SETPER = 3'd3, KIND_START = 3'd4, KIND_STOP = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_FREE = 2'd0, ST_STOPPED = 2'd1, ST_RUNNING = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0, STAT_NOFREE = 2'd1, STAT_BAD = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		SQ_IDLE, SQ_TSCAN, SQ_TDIV, SQ_TOUT,
		SQ_MSCAN, SQ_MDIV, SQ_CLR, SQ_OUT
	} seq_t;
endpackage
`default_nettype wire

// ===== hdl/mcpt_divider.sv =====
// ----------------------------------------------------------------------------
// mcpt_divider: shared restoring divider
// 33-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mcpt_divider
	import mcpt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [32:0]      quotient,
	output logic [31:0]      remainder
);
	logic [32:0] rem_q;
	logic [32:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	// shift in next dividend bit, try subtract
	assign trial = {rem_q, quo_q[32]} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[32]};
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[31:0];
endmodule
`default_nettype wire

// ===== hdl/multi_channel_periodic_timer_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_periodic_timer_core: bank of periodic timer slots
// Sequencer walks slots over a shared divider for ticks and divisor updates.
// ----------------------------------------------------------------------------
// Channel | Direction | Fields
// in      | request   | kind, slot, period_us, now_ms
// out     | result    | slot_out, fire_count, status, base_divisor, last
//
// A tick scans slots in order up to the last running slot, one per cycle
// but for running slots: each runs one divide if its period is nonzero and
// then one output handshake. Set period scans 16 slots and, on a new minimum,
// divides if it is under DivLimit and clears all 16 accumulators.
// Output register holds a result until taken; the sequencer waits there.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_channel_periodic_timer_core
	import mcpt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [3:0]  slot,
	input  wire logic [30:0] period_us,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       slot_out,
	output logic [16:0]      fire_count,
	output logic [1:0]       status,
	output logic [16:0]      base_divisor,
	output logic             last
);
	seq_t         state_q, state_d;
	slot_state_t  sst_q [NumSlots];
	logic [30:0]  per_q [NumSlots];
	logic [31:0]  acc_q [NumSlots];
	logic [31:0]  prev_q, minp_q, diff_q, mscan_q;
	logic         seen_q;
	logic [16:0]  div_q;
	logic [3:0]   idx_q;
	logic         pend_last_q;

	logic         dv_start, dv_done;
	logic [32:0]  dv_dividend, dv_q;
	logic [31:0]  dv_divisor, dv_r;
	logic [31:0]  clamp_ms;
	logic [31:0]  mscan_d;
	logic         more_run;

	mcpt_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend(dv_dividend), .divisor(dv_divisor),
		.done(dv_done), .quotient(dv_q), .remainder(dv_r)
	);

	// tick elapsed time clamp
	always_comb begin
		clamp_ms = now_ms - prev_q;
		if (clamp_ms > 32'd100) clamp_ms = 32'd100;
	end

	// running minimum including the slot under the scan index
	always_comb begin
		mscan_d = mscan_q;
		if (sst_q[idx_q] != ST_FREE && {1'b0, per_q[idx_q]} < mscan_q)
			mscan_d = {1'b0, per_q[idx_q]};
	end

	// any running slot beyond idx_q
	always_comb begin
		more_run = 1'b0;
		for (int i = 0; i < NumSlots; i++)
			if (i > int'(idx_q) && sst_q[i] == ST_RUNNING) more_run = 1'b1;
	end

	// divider operand select and start
	always_comb begin
		if (state_q == SQ_MSCAN) begin
			dv_dividend = 33'(mscan_d) * 33'd10000;
			dv_divisor  = 32'd8380;
		end else begin
			dv_dividend = {1'b0, acc_q[idx_q]} + {1'b0, diff_q};
			dv_divisor  = {1'b0, per_q[idx_q]};
		end
		dv_start = 1'b0;
		if (state_q == SQ_TSCAN && sst_q[idx_q] == ST_RUNNING && per_q[idx_q] != '0)
			dv_start = 1'b1;
		if (state_q == SQ_MSCAN && idx_q == 4'd15 && mscan_d != minp_q
		    && mscan_d < 32'(DivLimit))
			dv_start = 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: if (in_valid) begin
				if (kind == KIND_TICK)        state_d = SQ_TSCAN;
				else if (kind == KIND_SETPER && period_us != '0) state_d = SQ_MSCAN;
				else                          state_d = SQ_OUT;
			end
			SQ_TSCAN: if (sst_q[idx_q] == ST_RUNNING)
					state_d = (per_q[idx_q] != '0) ? SQ_TDIV : SQ_TOUT;
				else if (idx_q == 4'd15) state_d = SQ_IDLE;
			SQ_TDIV: if (dv_done) state_d = SQ_TOUT;
			SQ_TOUT: if (out_ready)
					state_d = (pend_last_q) ? SQ_IDLE : SQ_TSCAN;
			SQ_MSCAN: if (idx_q == 4'd15) begin
				if (mscan_d == minp_q)           state_d = SQ_OUT;
				else if (mscan_d < 32'(DivLimit)) state_d = SQ_MDIV;
				else                             state_d = SQ_CLR;
			end
			SQ_MDIV: if (dv_done) state_d = SQ_CLR;
			SQ_CLR:  if (idx_q == 4'd15) state_d = SQ_OUT;
			SQ_OUT:  if (out_ready) state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = (state_q == SQ_IDLE);
		out_valid = (state_q == SQ_OUT) || (state_q == SQ_TOUT);
		base_divisor = div_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= SQ_IDLE;
		else         state_q <= state_d;
	end

	// datapath and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumSlots; i++) begin
				sst_q[i] <= ST_FREE; per_q[i] <= '0; acc_q[i] <= '0;
			end
			prev_q <= '0; seen_q <= 1'b0; minp_q <= '1; div_q <= '0;
			idx_q <= '0;
			mscan_q <= '0; diff_q <= '0; pend_last_q <= 1'b0;
			slot_out <= '0; fire_count <= '0; status <= '0; last <= 1'b0;
		end else begin
			unique case (state_q)
				SQ_IDLE: if (in_valid) begin
					idx_q <= '0; mscan_q <= '1;
					slot_out <= slot; fire_count <= '0; status <= STAT_OK;
					last <= 1'b1;
					priority if (kind == KIND_TICK) begin
						diff_q <= seen_q ? clamp_ms * 32'd1000 : minp_q;
						seen_q <= 1'b1; prev_q <= now_ms;
					end else if (kind == KIND_ALLOC) begin
						status <= STAT_NOFREE; slot_out <= '0;
						for (int i = NumSlots - 1; i >= 0; i--)
							if (sst_q[i] == ST_FREE) begin
								status <= STAT_OK; slot_out <= SlotW'(i);
							end
						for (int i = 0; i < NumSlots; i++) begin
							automatic logic lower_free = 1'b0;
							for (int j = 0; j < i; j++)
								if (sst_q[j] == ST_FREE) lower_free = 1'b1;
							if (sst_q[i] == ST_FREE && !lower_free)
								sst_q[i] <= ST_STOPPED;
						end
					end else if (kind == KIND_RELEASE) begin
						sst_q[slot] <= ST_FREE;
					end else if (kind == KIND_SETPER) begin
						if (period_us == '0) status <= STAT_BAD;
						else per_q[slot] <= period_us;
					end else if (kind == KIND_START) begin
						if (sst_q[slot] == ST_STOPPED) sst_q[slot] <= ST_RUNNING;
					end else if (kind == KIND_STOP) begin
						if (sst_q[slot] == ST_RUNNING) sst_q[slot] <= ST_STOPPED;
					end else begin
						status <= STAT_BAD; slot_out <= '0;
					end
				end
				SQ_TSCAN: begin
					slot_out <= idx_q; status <= STAT_OK; fire_count <= '0;
					last <= !more_run; pend_last_q <= !more_run;
					if (sst_q[idx_q] == ST_RUNNING && per_q[idx_q] == '0)
						acc_q[idx_q] <= '0;
					if (sst_q[idx_q] != ST_RUNNING || per_q[idx_q] == '0)
						idx_q <= idx_q + 4'd1;
				end
				SQ_TDIV: if (dv_done) begin
					acc_q[idx_q] <= dv_r;
					fire_count <= (dv_q > 33'(FireMax)) ? 17'(FireMax) : dv_q[16:0];
					idx_q <= idx_q + 4'd1;
				end
				SQ_TOUT: ;
				SQ_MSCAN: begin
					mscan_q <= mscan_d;
					idx_q <= idx_q + 4'd1;
				end
				SQ_MDIV: if (dv_done) begin
					div_q <= dv_q[16:0];
					minp_q <= mscan_q;
				end
				SQ_CLR: begin
					if (idx_q == 4'd0 && mscan_q >= 32'(DivLimit)) begin
						div_q <= '0; minp_q <= mscan_q;
					end
					acc_q[idx_q] <= '0;
					idx_q <= idx_q + 4'd1;
				end
				SQ_OUT: ;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fire_count))
		else $error("result dropped");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (state_q == SQ_TDIV || state_q == SQ_MDIV))
		else $error("divider done out of sequence");
`endif
endmodule
`default_nettype wire
